FILE: design/scc_pkg.sv
// shared constants and controller/datapath interface types for the component search
package scc_pkg;

  localparam int MAX_V  = 64;
  localparam int MAX_E  = 256;
  localparam int VW     = 7;
  localparam int VIW    = $clog2(MAX_V);
  localparam int EIW    = $clog2(MAX_E);
  localparam int EW     = EIW + 1;
  localparam logic [EW-1:0] NIL_EDGE = EW'(MAX_E);

  typedef struct packed {
    logic [VW-1:0] vtx;
    logic [EW-1:0] edge_ptr;
    logic [VW-1:0] low;
    logic [VW-1:0] disc;
  } frame_t;

  typedef struct packed {
    logic add_start;
    logic add_commit;
    logic add_drop;
    logic run_start;
    logic scan_next;
    logic enter_s;
    logic enter_v;
    logic enter_ld;
    logic edge_rd;
    logic edge_ld;
    logic edge_upd;
    logic ret;
    logic pop_rd;
    logic pop_w;
    logic par_rd;
    logic par_ld;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic s_over;
    logic s_visited;
    logic te_nil;
    logic v_bad;
    logic v_visited;
    logic low_eq;
    logic depth_zero;
    logic is_root;
    logic out_free;
    logic held_valid;
  } stat_t;

endpackage

FILE: design/scc_ctrl.sv
// controller state machine sequencing edge loads and the depth-first search
module scc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  output logic           in_tready,
  input  scc_pkg::stat_t stat,
  output scc_pkg::cmd_t  cmd
);
  import scc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ADD   = 13'b0000000000010,
    S_SCAN  = 13'b0000000000100,
    S_ENTER = 13'b0000000001000,
    S_STEP  = 13'b0000000010000,
    S_EDGE  = 13'b0000000100000,
    S_EDGE2 = 13'b0000001000000,
    S_RET   = 13'b0000010000000,
    S_POPR  = 13'b0000100000000,
    S_POPW  = 13'b0001000000000,
    S_PARR  = 13'b0010000000000,
    S_PARL  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.run_start = 1'b1;
            state_nxt = S_SCAN;
          end else if (stat.add_ok) begin
            cmd.add_start = 1'b1;
            state_nxt = S_ADD;
          end else begin
            cmd.add_drop = 1'b1;
          end
        end
      end
      S_ADD: begin
        cmd.add_commit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.s_over) begin
          state_nxt = S_FIN;
        end else if (stat.s_visited) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.enter_s = 1'b1;
          state_nxt = S_ENTER;
        end
      end
      S_ENTER: begin
        cmd.enter_ld = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (stat.te_nil) begin
          state_nxt = S_RET;
        end else begin
          cmd.edge_rd = 1'b1;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_ld = 1'b1;
        state_nxt = stat.v_bad ? S_STEP : S_EDGE2;
      end
      S_EDGE2: begin
        if (!stat.v_visited) begin
          cmd.enter_v = 1'b1;
          state_nxt = S_ENTER;
        end else begin
          cmd.edge_upd = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_RET: begin
        cmd.ret = 1'b1;
        state_nxt = stat.low_eq ? S_POPR : S_PARR;
      end
      S_POPR: begin
        cmd.pop_rd = 1'b1;
        state_nxt = S_POPW;
      end
      S_POPW: begin
        if (!stat.held_valid || stat.out_free) begin
          cmd.pop_w = 1'b1;
          state_nxt = stat.is_root ? S_PARR : S_POPR;
        end
      end
      S_PARR: begin
        if (stat.depth_zero) begin
          cmd.scan_next = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.par_rd = 1'b1;
          state_nxt = S_PARL;
        end
      end
      S_PARL: begin
        cmd.par_ld = 1'b1;
        state_nxt = S_STEP;
      end
      S_FIN: begin
        if (!stat.held_valid || stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/scc_dp.sv
// datapath: edge store, per-vertex search state, call and pending stacks, result registers
module scc_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [scc_pkg::VW-1:0] cfg_data,
  input  logic [scc_pkg::VW-1:0] in_from,
  input  logic [scc_pkg::VW-1:0] in_to,
  input  scc_pkg::cmd_t         cmd,
  output scc_pkg::stat_t        stat,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [15:0]           out_tdata,
  output logic                  out_tlast
);
  import scc_pkg::*;

  logic [VW-1:0]  etgt_mem [MAX_E];
  logic [EW-1:0]  enext_mem [MAX_E];
  logic [EIW-1:0] vfirst_mem [MAX_V];
  logic [EIW-1:0] vlast_mem [MAX_V];
  logic [VW-1:0]  disc_mem [MAX_V];
  logic [VW-1:0]  pend_mem [MAX_V];
  frame_t         call_mem [MAX_V];

  logic [VW-1:0]  cfg_r;
  logic [VW-1:0]  n_w;
  logic [EW-1:0]  etot_r;
  logic           drop_r;
  logic [MAX_V-1:0] vhas_r, dv_r, onst_r;
  logic [VW-1:0]  from_r;
  logic [EIW-1:0] lq_r, vf_q_r;
  logic           lhv_r, hv_r;
  logic [VW-1:0]  s_r, time_r, comp_r, depth_r, ptop_r;
  logic [VW-1:0]  tu_r, tl_r, td_r, v_r, cl_r, root_r, disc_q_r, pq_r;
  logic [EW-1:0]  te_r;
  logic [VW-1:0]  et_q_r;
  logic [EW-1:0]  en_q_r;
  frame_t         cq_r, push_w;
  logic           held_v_r, held_end_r, held_drop_r;
  logic [VW-1:0]  held_vtx_r, held_comp_r;
  logic           out_v_r, out_last_r;
  logic [15:0]    out_data_r;

  logic [VW-1:0]  ev_w, ev_m1, from_m1, s_m1, v_m1, pq_m1, et_m1, tnext_w, dm1_w, pm1_w;
  logic [VW-1:0]  et_w;
  logic           out_free_w;

  assign n_w     = (cfg_r > VW'(MAX_V)) ? VW'(MAX_V) : cfg_r;
  assign ev_w    = cmd.enter_s ? s_r : v_r;
  assign ev_m1   = ev_w - 1'b1;
  assign from_m1 = in_from - 1'b1;
  assign s_m1    = s_r - 1'b1;
  assign v_m1    = v_r - 1'b1;
  assign pq_m1   = pq_r - 1'b1;
  assign et_w    = et_q_r;
  assign et_m1   = et_w - 1'b1;
  assign tnext_w = time_r + 1'b1;
  assign dm1_w   = depth_r - 1'b1;
  assign pm1_w   = ptop_r - 1'b1;
  assign out_free_w = !out_v_r || out_tready;
  assign push_w  = '{vtx: tu_r, edge_ptr: te_r, low: tl_r, disc: td_r};

  assign stat.add_ok     = (etot_r < EW'(MAX_E)) && (in_from != '0) && (in_from <= n_w) &&
                           (in_to != '0) && (in_to <= n_w);
  assign stat.s_over     = s_r > n_w;
  assign stat.s_visited  = dv_r[s_m1[VIW-1:0]];
  assign stat.te_nil     = te_r[EW-1];
  assign stat.v_bad      = (et_w == '0) || (et_w > n_w);
  assign stat.v_visited  = dv_r[v_m1[VIW-1:0]];
  assign stat.low_eq     = tl_r == td_r;
  assign stat.depth_zero = depth_r == '0;
  assign stat.is_root    = pq_r == root_r;
  assign stat.out_free   = out_free_w;
  assign stat.held_valid = held_v_r;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      etgt_mem[etot_r[EIW-1:0]] <= in_to;
    end
    if (cmd.add_start) begin
      enext_mem[etot_r[EIW-1:0]] <= NIL_EDGE;
    end else if (cmd.add_commit && lhv_r) begin
      enext_mem[lq_r] <= {1'b0, etot_r[EIW-1:0]};
    end
    if (cmd.edge_rd) begin
      et_q_r <= etgt_mem[te_r[EIW-1:0]];
      en_q_r <= enext_mem[te_r[EIW-1:0]];
    end
  end

  // per-vertex list heads and tails
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      vlast_mem[from_r[VIW-1:0]] <= etot_r[EIW-1:0];
      if (!lhv_r) begin
        vfirst_mem[from_r[VIW-1:0]] <= etot_r[EIW-1:0];
      end
    end
    if (cmd.add_start) begin
      lq_r <= vlast_mem[from_m1[VIW-1:0]];
    end
    if (cmd.enter_s || cmd.enter_v) begin
      vf_q_r <= vfirst_mem[ev_m1[VIW-1:0]];
    end
  end

  // discovery times, pending stack, call stack
  always_ff @(posedge clk) begin
    if (cmd.enter_s || cmd.enter_v) begin
      disc_mem[ev_m1[VIW-1:0]] <= tnext_w;
      pend_mem[ptop_r[VIW-1:0]] <= ev_w;
      if (depth_r != '0) begin
        call_mem[dm1_w[VIW-1:0]] <= push_w;
      end
    end
    if (cmd.edge_ld) begin
      disc_q_r <= disc_mem[et_m1[VIW-1:0]];
    end
    if (cmd.pop_rd) begin
      pq_r <= pend_mem[pm1_w[VIW-1:0]];
    end
    if (cmd.par_rd) begin
      cq_r <= call_mem[dm1_w[VIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_start) begin
      from_r <= from_m1;
      lhv_r  <= vhas_r[from_m1[VIW-1:0]];
    end
    if (cmd.enter_s || cmd.enter_v) begin
      hv_r <= vhas_r[ev_m1[VIW-1:0]];
      tu_r <= ev_w;
      tl_r <= tnext_w;
      td_r <= tnext_w;
    end
    if (cmd.enter_ld) begin
      te_r <= hv_r ? {1'b0, vf_q_r} : NIL_EDGE;
    end
    if (cmd.edge_ld) begin
      te_r <= en_q_r;
      v_r  <= et_w;
    end
    if (cmd.edge_upd && onst_r[v_m1[VIW-1:0]] && (disc_q_r < tl_r)) begin
      tl_r <= disc_q_r;
    end
    if (cmd.ret) begin
      cl_r   <= tl_r;
      root_r <= tu_r;
    end
    if (cmd.par_ld) begin
      tu_r <= cq_r.vtx;
      te_r <= cq_r.edge_ptr;
      td_r <= cq_r.disc;
      tl_r <= (cl_r < cq_r.low) ? cl_r : cq_r.low;
    end
    if (cmd.pop_w) begin
      held_vtx_r  <= pq_r;
      held_comp_r <= comp_r;
      held_end_r  <= stat.is_root;
      held_drop_r <= drop_r;
    end
    if (cmd.pop_w && held_v_r) begin
      out_data_r <= {held_drop_r, held_end_r, held_comp_r, held_vtx_r};
      out_last_r <= 1'b0;
    end else if (cmd.flush && held_v_r) begin
      out_data_r <= {held_drop_r, held_end_r, held_comp_r, held_vtx_r};
      out_last_r <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= VW'(MAX_V);
      etot_r   <= '0;
      drop_r   <= 1'b0;
      vhas_r   <= '0;
      dv_r     <= '0;
      onst_r   <= '0;
      s_r      <= '0;
      time_r   <= '0;
      comp_r   <= '0;
      depth_r  <= '0;
      ptop_r   <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (cmd.add_drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.add_commit) begin
        vhas_r[from_r[VIW-1:0]] <= 1'b1;
        etot_r <= etot_r + 1'b1;
      end
      if (cmd.run_start) begin
        s_r     <= VW'(1);
        time_r  <= '0;
        comp_r  <= '0;
        depth_r <= '0;
        ptop_r  <= '0;
        dv_r    <= '0;
        onst_r  <= '0;
      end
      if (cmd.scan_next) begin
        s_r <= s_r + 1'b1;
      end
      if (cmd.enter_s || cmd.enter_v) begin
        time_r  <= tnext_w;
        dv_r[ev_m1[VIW-1:0]]   <= 1'b1;
        onst_r[ev_m1[VIW-1:0]] <= 1'b1;
        ptop_r  <= ptop_r + 1'b1;
        depth_r <= depth_r + 1'b1;
      end
      if (cmd.ret) begin
        depth_r <= dm1_w;
        if (tl_r == td_r) begin
          comp_r <= comp_r + 1'b1;
        end
      end
      if (cmd.pop_w) begin
        ptop_r <= pm1_w;
        onst_r[pq_m1[VIW-1:0]] <= 1'b0;
        held_v_r <= 1'b1;
      end
      out_v_r <= ((cmd.pop_w || cmd.flush) && held_v_r) || (out_v_r && !out_tready);
      if (cmd.flush) begin
        held_v_r <= 1'b0;
        vhas_r   <= '0;
        etot_r   <= '0;
        drop_r   <= 1'b0;
      end
    end
  end

endmodule

FILE: design/strongly_connected_components.sv
// top level: strongly connected component search over a loaded directed edge list
// an edge load passes through the add state before the next request is taken; a dropped edge is taken in idle
// a run walks the vertices, edge lists and call and pending stacks and takes no request
// until it ends; edges with an out-of-range target are skipped
// each result leaves one pop behind its vertex, the last at run end; results stall on out_tready
// synchronous active-low reset: vertex count 64, edge store empty, drop flag clear
module strongly_connected_components (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,    // vertex_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // edge_from[6:0], edge_to[13:7], zero fill
  input  logic        in_tuser,    // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // vertex[6:0], component[13:7], component_end[14],
                                   // edges_dropped[15]
  output logic        out_tlast    // run_end
);
  import scc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_valid;

  assign cfg_ready  = 1'b1;
  assign ctrl_valid = in_tvalid;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (ctrl_valid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_from    (in_tdata[6:0]),
    .in_to      (in_tdata[13:7]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the strongly connected component search block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic       kind;
    logic [6:0] src;
    logic [6:0] dst;
  } req_t;

  typedef struct packed {
    logic [6:0] vtx;
    logic [6:0] comp;
    logic       comp_end;
    logic       last;
    logic       dropped;
  } scc_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tlast;

  always #6 clk = ~clk;

  strongly_connected_components u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // predictor state
  int unsigned vcount;
  int unsigned e_dst[NE];
  int unsigned e_nxt[NE];
  int unsigned v_first[NV+1];
  int unsigned v_last[NV+1];
  int unsigned e_cnt;
  bit          drop_seen;
  int unsigned disc[NV+1];
  int unsigned low[NV+1];
  bit          onstk[NV+1];
  int unsigned cs_v[NV+1];
  int unsigned cs_e[NV+1];
  int unsigned cs_n;
  int unsigned pend[NV+1];
  int unsigned pend_n;
  int unsigned tick;
  int unsigned comp_n;

  scc_res_t    comp_q[$];
  req_t        pending_req[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          n_sent = 0;
  longint      cycles = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void clear_edge_store();
    for (int i = 0; i <= NV; i++) begin
      v_first[i] = NE;
      v_last[i] = NE;
    end
    e_cnt = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void visit(int unsigned u);
    if (cs_n > NV || pend_n > NV) return;
    tick++;
    disc[u] = tick;
    low[u] = tick;
    pend[pend_n++] = u;
    onstk[u] = 1'b1;
    cs_v[cs_n] = u;
    cs_e[cs_n] = v_first[u];
    cs_n++;
  endfunction

  function automatic void pop_component(int unsigned root, ref int k);
    int unsigned p;
    scc_res_t r;
    comp_n++;
    while (pend_n > 0 && k < NV) begin
      pend_n--;
      p = pend[pend_n];
      onstk[p] = 1'b0;
      r.vtx = p[6:0];
      r.comp = comp_n[6:0];
      r.comp_end = (p == root);
      r.last = 1'b0;
      r.dropped = drop_seen;
      comp_q = {comp_q, r};
      k++;
      if (p == root) break;
    end
  endfunction

  function automatic void predict_scc(req_t q);
    int unsigned n, u, v, e, p;
    int k;
    n = (vcount > NV) ? NV : vcount;
    if (q.kind == KIND_RUN) begin
      for (int i = 0; i <= NV; i++) begin
        disc[i] = 0; low[i] = 0; onstk[i] = 0;
      end
      cs_n = 0; pend_n = 0; tick = 0; comp_n = 0; k = 0;
      for (int unsigned s = 1; s <= n; s++) begin
        if (disc[s] != 0) continue;
        visit(s);
        while (cs_n > 0) begin
          u = cs_v[cs_n-1];
          e = cs_e[cs_n-1];
          if (e < NE) begin
            cs_e[cs_n-1] = e_nxt[e];
            v = e_dst[e];
            if (v < 1 || v > n) continue;
            if (disc[v] == 0) visit(v);
            else if (onstk[v] && disc[v] < low[u]) low[u] = disc[v];
          end else begin
            cs_n--;
            if (low[u] == disc[u]) pop_component(u, k);
            if (cs_n > 0) begin
              p = cs_v[cs_n-1];
              if (low[u] < low[p]) low[p] = low[u];
            end
          end
        end
      end
      if (k > 0) comp_q[comp_q.size()-1].last = 1'b1;
      clear_edge_store();
    end else begin
      if (e_cnt >= NE || q.src < 1 || q.src > n || q.dst < 1 || q.dst > n) begin
        drop_seen = 1'b1;
        return;
      end
      e_dst[e_cnt] = q.dst;
      e_nxt[e_cnt] = NE;
      if (v_last[q.src] < NE) e_nxt[v_last[q.src]] = e_cnt;
      else v_first[q.src] = e_cnt;
      v_last[q.src] = e_cnt;
      e_cnt++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) begin
          predict_scc(pending_req[0]);
          void'(pending_req.pop_front());
          n_sent <= n_sent + 1;
        end
        if (pending_req.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_req[0].kind;
          in_tdata <= {2'b00, pending_req[0].dst, pending_req[0].src};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // monitor
  always @(posedge clk) begin
    scc_res_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[6:0], out_tdata[13:7], out_tdata[14], out_tlast, out_tdata[15]};
      if (comp_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp_r = comp_q.pop_front();
        if (got.vtx != exp_r.vtx)
          report($sformatf("vertex %0d exp %0d", got.vtx, exp_r.vtx));
        if (got.comp != exp_r.comp)
          report($sformatf("component %0d exp %0d", got.comp, exp_r.comp));
        if (got.comp_end != exp_r.comp_end)
          report($sformatf("component_end %0d exp %0d", got.comp_end, exp_r.comp_end));
        if (got.last != exp_r.last)
          report($sformatf("run_end %0d exp %0d", got.last, exp_r.last));
        if (got.dropped != exp_r.dropped)
          report($sformatf("edges_dropped %0d exp %0d", got.dropped, exp_r.dropped));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_edge(input int s, input int d);
    req_t q;
    q.kind = KIND_EDGE; q.src = s[6:0]; q.dst = d[6:0];
    pending_req = {pending_req, q};
  endtask

  task automatic push_run();
    req_t q;
    q.kind = KIND_RUN; q.src = 7'($urandom); q.dst = 7'($urandom);
    pending_req = {pending_req, q};
  endtask

  task automatic drain();
    while (pending_req.size() > 0 || in_tvalid) @(posedge clk);
    while (comp_q.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic set_count(input int c);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c[6:0];
    do @(posedge clk); while (!cfg_ready);
    vcount = c;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n, m;
    vcount = 64;
    clear_edge_store();
    for (int i = 0; i < NE; i++) begin e_dst[i] = 0; e_nxt[i] = 0; end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset count, cycle plus tail, bad endpoints
    push_edge(1, 2); push_edge(2, 3); push_edge(3, 1); push_edge(3, 64);
    push_edge(64, 64); push_edge(0, 5); push_edge(5, 0); push_edge(65, 1);
    push_edge(127, 127); push_edge(4, 1);
    push_run();
    drain();
    set_count(1);
    push_edge(1, 1); push_edge(1, 2); push_run();
    drain();
    set_count(0);
    push_edge(1, 1); push_run();
    drain();
    set_count(127);
    push_edge(10, 20); push_edge(20, 10); push_run();
    drain();
    // full edge store
    set_count(8);
    for (int i = 0; i < NE + 3; i++) push_edge($urandom_range(1, 8), $urandom_range(1, 8));
    push_run();
    drain();
    // count lowered after loading
    set_count(10);
    push_edge(1, 9); push_edge(9, 1); push_edge(2, 3);
    drain();
    set_count(5);
    push_run();
    drain();

    while (n_sent < 330) begin
      case ($urandom_range(3))
        0: n = $urandom_range(2, 8);
        1: n = $urandom_range(2, 20);
        2: n = 64;
        default: n = $urandom_range(0, 127);
      endcase
      set_count(n);
      quiet = ($urandom_range(5) == 0);
      m = $urandom_range(1, 30);
      for (int i = 0; i < m; i++) begin
        if ($urandom_range(9) == 0)
          push_edge($urandom_range(0, 127), $urandom_range(0, 127));
        else
          push_edge($urandom_range(1, (n < 1) ? 1 : (n > 64 ? 64 : n)),
                    $urandom_range(1, (n < 1) ? 1 : (n > 64 ? 64 : n)));
      end
      push_run();
      drain();
      quiet = 1'b0;
    end

    if (errors == 0 && comp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
